// ===== hw/rtl/sms_pkg.sv =====
package sms_pkg;

    localparam int DEV_W       = 40;
    localparam int COUNT_OUT_W = 4;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ===== hw/rtl/sms_div.sv =====
module sms_div
    import sms_pkg::*;
#(
    parameter int DVD_W = 84,
    parameter int DSR_W = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output unit_stat_t       stat
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DSR_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DSR_W:0]    trial;
    logic [DSR_W:0]    trial_diff;
    logic              take;

    always_comb
    begin
        trial      = {rem_reg, dvd_reg[DVD_W-1]};
        trial_diff = trial - {1'b0, divisor};
        take       = (trial >= {1'b0, divisor});
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            step_next = STEP_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift the quotient bit in where the dividend bit leaves
            dvd_next  = {dvd_reg[DVD_W-2:0], take};
            rem_next  = take ? trial_diff[DSR_W-1:0] : trial[DSR_W-1:0];
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient  = dvd_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hw/rtl/sms_sqacc.sv =====
module sms_sqacc
    import sms_pkg::*;
#(
    parameter int SMP_W = 32,
    parameter int ACC_W = 68
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             start,
    input  logic [SMP_W-1:0] x,
    input  logic [SMP_W-1:0] mean,
    output logic [ACC_W-1:0] acc,
    output unit_stat_t       stat
);

    localparam int PROD_W = 2 * SMP_W;
    localparam int STEP_W = $clog2(SMP_W + 1);

    logic [SMP_W-1:0]  md_reg, md_next;
    logic [PROD_W-1:0] mc_reg, mc_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [SMP_W-1:0]  diff;

    always_comb
    begin
        diff      = (x >= mean) ? (x - mean) : (mean - x);
        md_next   = md_reg;
        mc_next   = mc_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (clear)
        begin
            acc_next = '0;
        end
        if (start)
        begin
            md_next   = diff;
            mc_next   = PROD_W'(diff);
            step_next = STEP_W'(SMP_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // add the shifted multiplicand for each set multiplier bit
            if (md_reg[0])
            begin
                acc_next = acc_reg + ACC_W'(mc_reg);
            end
            md_next   = md_reg >> 1;
            mc_next   = mc_reg << 1;
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        md_reg  <= md_next;
        mc_reg  <= mc_next;
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign acc       = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hw/rtl/sms_sqrt.sv =====
module sms_sqrt
    import sms_pkg::*;
#(
    parameter int RAD_W = 84
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [RAD_W-1:0]         radicand,
    output logic [(RAD_W+1)/2-1:0]   root,
    output unit_stat_t               stat
);

    localparam int RT_W   = (RAD_W + 1) / 2;
    localparam int PAD_W  = 2 * RT_W;
    localparam int STEP_W = $clog2(RT_W + 1);

    logic [PAD_W-1:0]  rad_reg, rad_next;
    logic [RT_W:0]     rm_reg, rm_next;
    logic [RT_W-1:0]   root_reg, root_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [RT_W+2:0]   rm_trial;
    logic [RT_W+2:0]   test;
    logic [RT_W+2:0]   rm_diff;
    logic              take;

    always_comb
    begin
        rm_trial  = {rm_reg, rad_reg[PAD_W-1:PAD_W-2]};
        test      = {1'b0, root_reg, 2'b01};
        rm_diff   = rm_trial - test;
        take      = (rm_trial >= test);
        rad_next  = rad_reg;
        rm_next   = rm_reg;
        root_next = root_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = PAD_W'(radicand);
            rm_next   = '0;
            root_next = '0;
            step_next = STEP_W'(RT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // bring down one bit pair and settle one root bit
            rad_next  = {rad_reg[PAD_W-3:0], 2'b00};
            rm_next   = take ? rm_diff[RT_W:0] : rm_trial[RT_W:0];
            root_next = {root_reg[RT_W-2:0], take};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rm_reg   <= rm_next;
        root_reg <= root_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hw/rtl/sample_mean_stddev.sv =====
// Channel | Dir | Words                       | Fields (lowest bit first)
// s_*     | in  | one sample per word         | tdata: sample; tlast: last
// m_*     | out | one result per set of words | tdata: mean, deviation, sample_count;
//         |     |                             | tuser: overflowed
// Loading takes one word per cycle. After the last word of a set of n > 2 samples the
// block stays busy while the bit-serial divider runs twice, the shift-add multiplier runs
// once per sample and the root unit settles one bit pair a cycle. Sets of two or fewer
// samples skip the arithmetic and report zero mean and deviation. No clearing pass
// after reset. A result waiting in the output register stalls only the end of the next set.
module sample_mean_stddev
    import sms_pkg::*;
#(
    parameter int MAX_SAMPLES = 8,
    parameter int SAMPLE_BITS = 32,
    parameter int FRAC_BITS   = 8
)
(
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  s_tvalid,
    output logic                                                  s_tready,
    // sample
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]              s_tdata,
    input  logic                                                  s_tlast,
    output logic                                                  m_tvalid,
    input  logic                                                  m_tready,
    // mean, deviation, sample_count
    output logic [((SAMPLE_BITS + DEV_W + COUNT_OUT_W + 7) / 8) * 8 - 1:0] m_tdata,
    // overflowed
    output logic                                                  m_tuser
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int ACC_W = 2 * SAMPLE_BITS + CNT_W;
    localparam int DVD_W = ACC_W + 2 * FRAC_BITS;
    localparam int RT_W  = (DVD_W + 1) / 2;
    localparam int OUT_W = ((SAMPLE_BITS + DEV_W + COUNT_OUT_W + 7) / 8) * 8;

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_MEAN   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_MSTART = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_ROOT   = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    logic [2:0]             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic                   drop_reg, drop_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [SAMPLE_BITS-1:0] mean_reg, mean_next;
    logic [DEV_W-1:0]       dev_reg, dev_next;
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_BITS-1:0] out_mean_reg;
    logic [DEV_W-1:0]       out_dev_reg;
    logic [COUNT_OUT_W-1:0] out_cnt_reg;
    logic                   out_ovf_reg;

    logic [SAMPLE_BITS-1:0] store_mem [MAX_SAMPLES];

    logic [SAMPLE_BITS-1:0] sample;
    logic                   accept;
    logic                   room;
    logic                   wr_en;
    logic [CNT_W-1:0]       cnt_after;
    logic [SUM_W-1:0]       sum_after;
    logic [CNT_W-1:0]       idx_last;
    logic                   out_load;

    logic                   div_start;
    logic [DVD_W-1:0]       div_dividend;
    logic [DVD_W-1:0]       div_quot;
    unit_stat_t             div_stat;
    logic                   sq_clear;
    logic                   sq_start;
    logic [ACC_W-1:0]       sq_acc;
    unit_stat_t             sq_stat;
    logic                   rt_start;
    logic [RT_W-1:0]        rt_root;
    unit_stat_t             rt_stat;

    sms_div #(
        .DVD_W (DVD_W),
        .DSR_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cnt_reg),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    sms_sqacc #(
        .SMP_W (SAMPLE_BITS),
        .ACC_W (ACC_W)
    ) u_sqacc (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (sq_clear),
        .start (sq_start),
        .x     (rd_data_reg),
        .mean  (mean_reg),
        .acc   (sq_acc),
        .stat  (sq_stat)
    );

    sms_sqrt #(
        .RAD_W (DVD_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rt_start),
        .radicand (div_quot),
        .root     (rt_root),
        .stat     (rt_stat)
    );

    assign sample    = s_tdata[SAMPLE_BITS-1:0];
    assign s_tready  = (state_reg == ST_LOAD);
    assign accept    = s_tvalid && s_tready;
    assign room      = (cnt_reg < CNT_W'(MAX_SAMPLES));
    assign wr_en     = accept && room;
    assign cnt_after = room ? (cnt_reg + 1'b1) : cnt_reg;
    assign sum_after = room ? (sum_reg + SUM_W'(sample)) : sum_reg;
    assign idx_last  = CNT_W'(idx_reg) + CNT_W'(1);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        drop_next    = drop_reg;
        idx_next     = idx_reg;
        mean_next    = mean_reg;
        dev_next     = dev_reg;
        div_start    = 1'b0;
        div_dividend = DVD_W'(sum_after);
        sq_clear     = 1'b0;
        sq_start     = 1'b0;
        rt_start     = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    cnt_next  = cnt_after;
                    sum_next  = sum_after;
                    drop_next = drop_reg | !room;
                    if (s_tlast)
                    begin
                        if (cnt_after > CNT_W'(2))
                        begin
                            div_start  = 1'b1;
                            sq_clear   = 1'b1;
                            state_next = ST_MEAN;
                        end
                        else
                        begin
                            mean_next  = '0;
                            dev_next   = '0;
                            state_next = ST_OUT;
                        end
                    end
                end
            end
            ST_MEAN:
            begin
                if (div_stat.done)
                begin
                    mean_next  = div_quot[SAMPLE_BITS-1:0];
                    idx_next   = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_MSTART;
            end
            ST_MSTART:
            begin
                sq_start   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (sq_stat.done)
                begin
                    if (idx_last == cnt_reg)
                    begin
                        div_start    = 1'b1;
                        div_dividend = DVD_W'(sq_acc) << (2 * FRAC_BITS);
                        state_next   = ST_DIV;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    rt_start   = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (rt_stat.done)
                begin
                    dev_next   = DEV_W'(rt_root);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    cnt_next   = '0;
                    sum_next   = '0;
                    drop_next  = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        priority if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[cnt_reg[IDX_W-1:0]] <= sample;
        end
        rd_data_reg <= store_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        mean_reg <= mean_next;
        dev_reg  <= dev_next;
        if (out_load)
        begin
            out_mean_reg <= mean_reg;
            out_dev_reg  <= dev_reg;
            out_cnt_reg  <= COUNT_OUT_W'(cnt_reg);
            out_ovf_reg  <= drop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            drop_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            sum_reg      <= sum_next;
            drop_reg     <= drop_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({out_cnt_reg, out_dev_reg, out_mean_reg});
    assign m_tuser  = out_ovf_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond buffer depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(div_stat.busy && rt_stat.busy))
        else $error("divider and root unit busy together");

    assert property (@(posedge clk) disable iff (!rst_n)
        sq_stat.busy |-> (state_reg == ST_MUL))
        else $error("multiplier running outside its pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_OUT))
        else $error("result word raised outside the output step");

endmodule
